>>> hw/rtl/clpt_pkg.sv
// shared types and constants of the calibrated pot level tracker
// used by clpt_ctrl, clpt_datapath and calibrated_pot_level_tracker

package clpt_pkg;

    localparam int SAMPLE_W      = 10;
    localparam int LEVEL_W       = 7;
    localparam int FULL_SCALE    = 1023;
    localparam int ARM_THRESHOLD = 511;
    localparam int DEADBAND      = 8;
    localparam int LEVEL_SHIFT   = 3;
    // quotient bits once the saturating case is split off
    localparam int DIV_STEPS     = 10;
    localparam int CNT_W         = 4;
    localparam int NUM_W         = SAMPLE_W + DIV_STEPS;

    localparam logic OP_CONVERT   = 1'b0;
    localparam logic OP_CALIBRATE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LEARN,
        ST_PREP,
        ST_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic capture;   // latch the incoming request
        logic learn;     // widen the calibration range
        logic prep;      // form numerator and divisor
        logic div_step;  // one restoring division step
        logic emit;      // write the result register
        logic is_cal;    // result of a calibrate request
    } cmd_t;

    typedef struct packed {
        logic op_cal;    // captured request is a calibrate sample
        logic div_last;  // final division step this cycle
        logic out_free;  // result register can take a new value
    } status_t;

endpackage

>>> hw/rtl/calibrated_pot_level_tracker.sv
// top level of the calibrated pot level tracker (range map with deadband)
// depends on clpt_pkg, clpt_ctrl and clpt_datapath
//
//   channel   dir   handshake           payload
//   s_        in    s_tvalid/s_tready   s_tuser = op, s_tdata = sample
//   m_        out   m_tvalid/m_tready   m_tdata = changed, level
//
// a convert request passes from accept to result register through capture,
// a learn/decode state, a prep state, ten restoring divider steps and emit;
// a calibrate request passes through capture, learn and emit.
// synchronous active-low reset sets range 0..1023 and clears the armed flag,
// the last reported value and the result valid; no clearing pass is needed.
// a stalled result holds in the output register; the next request is taken
// while it waits, and only its emit step waits for the register to free up.

module calibrated_pot_level_tracker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [9:0] sample, [15:10] zero
    input  logic        s_tuser,   // [0] op (0 convert, 1 calibrate)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // [0] changed, [7:1] level
);

    clpt_pkg::cmd_t    cmd;
    clpt_pkg::status_t status;

    logic                          out_changed;
    logic [clpt_pkg::LEVEL_W-1:0]  out_level;

    // sequencer: decides which datapath step runs each cycle
    clpt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // range state, divider, deadband check and result register
    clpt_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .status      (status),
        .in_op       (s_tuser),
        .in_sample   (s_tdata[clpt_pkg::SAMPLE_W-1:0]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .out_changed (out_changed),
        .out_level   (out_level)
    );

    // pack result fields, changed in the lowest bit
    assign m_tdata = {out_level, out_changed};

endmodule

>>> hw/rtl/clpt_ctrl.sv
// controller state machine of the pot level tracker
// depends on clpt_pkg; drives clpt_datapath through cmd_t

module clpt_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  clpt_pkg::status_t status,
    output clpt_pkg::cmd_t    cmd
);

    clpt_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= clpt_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            clpt_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = clpt_pkg::ST_LEARN;
                end
            end
            clpt_pkg::ST_LEARN: begin
                // learn state only acts for calibrate requests
                if (status.op_cal) begin
                    state_next = clpt_pkg::ST_EMIT;
                end else begin
                    state_next = clpt_pkg::ST_PREP;
                end
            end
            clpt_pkg::ST_PREP: begin
                state_next = clpt_pkg::ST_DIV;
            end
            clpt_pkg::ST_DIV: begin
                if (status.div_last) begin
                    state_next = clpt_pkg::ST_EMIT;
                end
            end
            clpt_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = clpt_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = clpt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            clpt_pkg::ST_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            clpt_pkg::ST_LEARN: begin
                cmd.learn = status.op_cal;
            end
            clpt_pkg::ST_PREP: begin
                cmd.prep = 1'b1;
            end
            clpt_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
            end
            clpt_pkg::ST_EMIT: begin
                cmd.emit   = status.out_free;
                cmd.is_cal = status.op_cal;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/clpt_datapath.sv
// datapath of the pot level tracker: range, divider, deadband, result register
// depends on clpt_pkg; commanded by clpt_ctrl

module clpt_datapath (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  clpt_pkg::cmd_t             cmd,
    output clpt_pkg::status_t          status,
    input  logic                       in_op,
    input  logic [clpt_pkg::SAMPLE_W-1:0] in_sample,
    input  logic                       m_tready,
    output logic                       m_tvalid,
    output logic                       out_changed,
    output logic [clpt_pkg::LEVEL_W-1:0] out_level
);

    localparam int SW = clpt_pkg::SAMPLE_W;
    localparam int NW = clpt_pkg::NUM_W;

    logic          op_reg;
    logic [SW-1:0] sample_reg;
    logic          armed_reg, armed_next;
    logic [SW-1:0] low_reg, low_next;
    logic [SW-1:0] high_reg, high_next;
    logic [SW-1:0] last_reg;
    logic [NW-1:0] rem_reg;
    logic [SW-1:0] den_reg;
    logic [SW-1:0] quo_reg;
    logic [clpt_pkg::CNT_W-1:0] cnt_reg;
    logic          sat_reg;
    logic          neg_reg;
    logic          valid_reg;
    logic          changed_reg;
    logic [clpt_pkg::LEVEL_W-1:0] level_reg;

    // learn
    logic [SW-1:0] thr;
    assign thr = SW'(clpt_pkg::ARM_THRESHOLD);

    always_comb begin
        armed_next = armed_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        if (!armed_reg && sample_reg > thr) begin
            armed_next = 1'b1;
            high_next  = sample_reg;
            low_next   = thr;
        end
        if (armed_next) begin
            if (sample_reg > high_next) begin
                high_next = sample_reg;
            end else if (sample_reg < low_next) begin
                low_next = sample_reg;
            end
        end
    end

    // numerator (s - low) * 1023 as (d << 10) - d, divisor high - low
    logic [SW:0]   diff_in;
    logic [NW-1:0] num;
    logic [SW-1:0] den;
    logic          sat;

    assign diff_in = {1'b0, sample_reg} - {1'b0, low_reg};
    assign num     = {diff_in[SW-1:0], {clpt_pkg::DIV_STEPS{1'b0}}}
                   - {{clpt_pkg::DIV_STEPS{1'b0}}, diff_in[SW-1:0]};
    assign den     = (high_reg > low_reg) ? (high_reg - low_reg) : SW'(1);
    // quotient would be 1024 or more: clamp without dividing
    assign sat     = num >= {den, {clpt_pkg::DIV_STEPS{1'b0}}};

    // restoring division step
    logic [NW-1:0] trial;
    logic          ge;
    assign trial = {{clpt_pkg::DIV_STEPS{1'b0}}, den_reg} << cnt_reg;
    assign ge    = rem_reg >= trial;

    // clamp and deadband
    logic [SW-1:0]        v;
    logic signed [SW:0]   gap;
    logic                 report;

    always_comb begin
        if (neg_reg) begin
            v = '0;
        end else if (sat_reg) begin
            v = SW'(clpt_pkg::FULL_SCALE);
        end else begin
            v = quo_reg;
        end
    end

    assign gap    = $signed({1'b0, last_reg}) - $signed({1'b0, v});
    assign report = (gap >= $signed((SW+1)'(clpt_pkg::DEADBAND)))
                 || (gap <= -$signed((SW+1)'(clpt_pkg::DEADBAND)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            armed_reg <= 1'b0;
            low_reg   <= '0;
            high_reg  <= SW'(clpt_pkg::FULL_SCALE);
            last_reg  <= '0;
            valid_reg <= 1'b0;
        end else begin
            if (cmd.learn) begin
                armed_reg <= armed_next;
                low_reg   <= low_next;
                high_reg  <= high_next;
            end
            if (cmd.emit) begin
                valid_reg <= 1'b1;
                if (!cmd.is_cal && report) begin
                    last_reg <= (v >> clpt_pkg::LEVEL_SHIFT) << clpt_pkg::LEVEL_SHIFT;
                end
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg     <= in_op;
            sample_reg <= in_sample;
        end
        if (cmd.prep) begin
            rem_reg <= num;
            den_reg <= den;
            sat_reg <= sat;
            neg_reg <= diff_in[SW];
            quo_reg <= '0;
            cnt_reg <= clpt_pkg::CNT_W'(clpt_pkg::DIV_STEPS - 1);
        end else if (cmd.div_step) begin
            if (ge) begin
                rem_reg <= rem_reg - trial;
            end
            quo_reg <= {quo_reg[SW-2:0], ge};
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.emit) begin
            if (!cmd.is_cal && report) begin
                changed_reg <= 1'b1;
                level_reg   <= v[SW-1:clpt_pkg::LEVEL_SHIFT];
            end else begin
                changed_reg <= 1'b0;
                level_reg   <= '0;
            end
        end
    end

    assign status.op_cal   = (op_reg == clpt_pkg::OP_CALIBRATE);
    assign status.div_last = (cnt_reg == '0);
    assign status.out_free = !valid_reg || m_tready;

    assign m_tvalid    = valid_reg;
    assign out_changed = changed_reg;
    assign out_level   = level_reg;

endmodule
